// File: design/flvtp_pkg.sv
`default_nettype none

package flvtp_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_SKIP,
    PH_THEAD,
    PH_PAYLOAD,
    PH_PREV,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_TAG     = 2'd1,
    ST_BAD_HDR = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

  localparam logic [1:0] EX_NONE  = 2'd0;
  localparam logic [1:0] EX_FLAGS = 2'd1;
  localparam logic [1:0] EX_PTYPE = 2'd2;
  localparam logic [1:0] EX_CTIME = 2'd3;

  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_L = 8'h4C;
  localparam logic [7:0] SIG_V = 8'h56;

  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;
  localparam logic [3:0] CODEC_AVC  = 4'd7;
  localparam logic [3:0] CODEC_HEVC = 4'd12;
  localparam logic [3:0] SOUND_AAC  = 4'd10;

  localparam logic [3:0] FILE_HDR_LAST = 4'd8;
  localparam logic [3:0] TAG_HDR_LAST  = 4'd10;
  localparam logic [3:0] PREV_SIZE_LEN = 4'd4;
  localparam logic [3:0] FC_MAX        = 4'd15;
  localparam int         PREV_SIZE_PAD = 4;

  localparam logic [15:0] TAG_LIMIT_RESET = 16'd10000;

  typedef struct packed {
    status_t           status;
    logic [1:0]        extra_valid;
    logic [7:0]        tag_type;
    logic [23:0]       data_size;
    logic [31:0]       timestamp;
    logic [23:0]       stream_id;
    logic [31:0]       position;
    logic [7:0]        media_flags;
    logic [7:0]        packet_type;
    logic signed [23:0] composition_time;
  } rec_t;

endpackage

`default_nettype wire

// File: design/flvtp_skid.sv
`default_nettype none

module flvtp_skid
  import flvtp_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  rec_t in_data,
  output logic out_valid,
  input  wire  out_ready,
  output rec_t out_data
);

  rec_t main_data;
  rec_t skid_data;
  logic main_valid;
  logic skid_valid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_data  <= in_data;
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: design/flvtp_core.sv
`default_nettype none

module flvtp_core
  import flvtp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         accept,
  input  wire  [7:0]  data_byte,
  input  wire         stream_end,
  input  wire  [15:0] tag_limit,
  output logic        res_valid,
  output rec_t        res
);

  localparam int SW = (POSITION_BITS > 33) ? POSITION_BITS : 33;
  localparam int PW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  typedef enum logic [1:0] {
    RK_ZERO,
    RK_HEADER,
    RK_RECORD
  } rec_kind_t;

  phase_t                   phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position;
  logic [3:0]               field_count, field_count_next;
  logic [POSITION_BITS-1:0] skip_target, skip_target_next;
  logic [23:0]              payload_left, payload_left_next;
  logic [15:0]              tags_seen, tags_seen_next;
  logic [63:0]              rec_fields, rec_fields_next;
  logic [31:0]              rec_low, rec_low_next;
  logic [7:0]               rec_ptype, rec_ptype_next;
  logic [23:0]              rec_ctime, rec_ctime_next;
  logic [1:0]               extra_count, extra_count_next;
  logic [POSITION_BITS-1:0] tag_start, tag_start_next;

  logic [POSITION_BITS-1:0] pos_inc;
  logic [SW-1:0]            skip_sum;
  logic [PW-1:0]            start_ext;
  logic [7:0]               ty;
  logic [23:0]              size;
  logic [7:0]               mf;
  logic                     emit;
  status_t                  emit_status;
  rec_kind_t                emit_kind;

  assign pos_inc   = byte_position + POSITION_BITS'(1);
  assign ty        = rec_fields[7:0];
  assign size      = rec_fields[31:8];
  assign mf        = rec_low[31:24];
  assign skip_sum  = SW'(rec_low_next) + SW'(PREV_SIZE_PAD);
  assign start_ext = PW'(tag_start_next);

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    skip_target_next  = skip_target;
    payload_left_next = payload_left;
    tags_seen_next    = tags_seen;
    rec_fields_next   = rec_fields;
    rec_low_next      = rec_low;
    rec_ptype_next    = rec_ptype;
    rec_ctime_next    = rec_ctime;
    extra_count_next  = extra_count;
    tag_start_next    = tag_start;
    emit              = 1'b0;
    emit_status       = ST_BAD_HDR;
    emit_kind         = RK_ZERO;

    unique case (phase)
      PH_SIG: begin
        if ((field_count == 4'd0 && data_byte != SIG_F) ||
            (field_count == 4'd1 && data_byte != SIG_L) ||
            (field_count == 4'd2 && data_byte != SIG_V)) begin
          emit       = 1'b1;
          phase_next = PH_STOP;
        end else begin
          if (field_count == 4'd3) begin
            rec_fields_next[7:0] = data_byte;
          end else if (field_count == 4'd4) begin
            rec_fields_next[15:8] = data_byte;
          end else if (field_count > 4'd4) begin
            rec_low_next = {rec_low[23:0], data_byte};
          end
          field_count_next = field_count + 4'd1;
          if (field_count >= FILE_HDR_LAST) begin
            emit             = 1'b1;
            emit_status      = ST_HEADER;
            emit_kind        = RK_HEADER;
            skip_target_next = skip_sum[POSITION_BITS-1:0];
            phase_next       = (skip_sum[POSITION_BITS-1:0] > pos_inc) ? PH_SKIP : PH_THEAD;
            field_count_next = 4'd0;
          end
        end
      end
      PH_SKIP: begin
        if (pos_inc >= skip_target) begin
          phase_next = PH_THEAD;
        end
      end
      PH_THEAD: begin
        if (field_count == 4'd0 && tags_seen >= tag_limit) begin
          phase_next = PH_STOP;
        end else begin
          if (field_count == 4'd0) begin
            tag_start_next   = byte_position;
            rec_fields_next  = '0;
            rec_low_next     = '0;
            rec_ptype_next   = '0;
            rec_ctime_next   = '0;
            extra_count_next = EX_NONE;
          end
          case (field_count)
            4'd0:    rec_fields_next[7:0]   = data_byte;
            4'd1:    rec_fields_next[31:24] = data_byte;
            4'd2:    rec_fields_next[23:16] = data_byte;
            4'd3:    rec_fields_next[15:8]  = data_byte;
            4'd4:    rec_fields_next[55:48] = data_byte;
            4'd5:    rec_fields_next[47:40] = data_byte;
            4'd6:    rec_fields_next[39:32] = data_byte;
            4'd7:    rec_fields_next[63:56] = data_byte;
            4'd8:    rec_low_next[23:16]    = data_byte;
            4'd9:    rec_low_next[15:8]     = data_byte;
            4'd10:   rec_low_next[7:0]      = data_byte;
            default: ;
          endcase
          field_count_next = field_count + 4'd1;
          if (field_count >= TAG_HDR_LAST) begin
            if (((rec_fields_next[7:0] == TAG_AUDIO || rec_fields_next[7:0] == TAG_VIDEO) &&
                 rec_fields_next[31:8] == 24'd0) ||
                (rec_fields_next[7:0] == TAG_SCRIPT && rec_fields_next[31:8] < 24'd2)) begin
              emit        = 1'b1;
              emit_status = ST_SHORT;
              emit_kind   = RK_RECORD;
              phase_next  = PH_STOP;
            end else begin
              payload_left_next = rec_fields_next[31:8];
              field_count_next  = 4'd0;
              phase_next = (rec_fields_next[31:8] != 24'd0) ? PH_PAYLOAD : PH_PREV;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if ((ty == TAG_AUDIO || ty == TAG_VIDEO) && field_count == 4'd0) begin
          rec_low_next[31:24] = data_byte;
          extra_count_next    = EX_FLAGS;
        end else if (ty == TAG_VIDEO && (mf[3:0] == CODEC_AVC || mf[3:0] == CODEC_HEVC) &&
                     size >= 24'd5) begin
          case (field_count)
            4'd1: begin
              rec_ptype_next   = data_byte;
              extra_count_next = EX_PTYPE;
            end
            4'd2: rec_ctime_next[23:16] = data_byte;
            4'd3: rec_ctime_next[15:8]  = data_byte;
            4'd4: begin
              rec_ctime_next[7:0] = data_byte;
              extra_count_next    = EX_CTIME;
            end
            default: ;
          endcase
        end else if (ty == TAG_AUDIO && field_count == 4'd1 && mf[7:4] == SOUND_AAC) begin
          rec_ptype_next   = data_byte;
          extra_count_next = EX_PTYPE;
        end
        if (field_count < FC_MAX) begin
          field_count_next = field_count + 4'd1;
        end
        payload_left_next = payload_left - 24'd1;
        if (payload_left == 24'd1) begin
          field_count_next = 4'd0;
          phase_next       = PH_PREV;
        end
      end
      PH_PREV: begin
        field_count_next = field_count + 4'd1;
        if (field_count + 4'd1 >= PREV_SIZE_LEN) begin
          emit        = 1'b1;
          emit_status = ST_TAG;
          emit_kind   = RK_RECORD;
          if (tags_seen != 16'hFFFF) begin
            tags_seen_next = tags_seen + 16'd1;
          end
          field_count_next = 4'd0;
          phase_next       = PH_THEAD;
        end
      end
      PH_STOP: ;
      default: ;
    endcase

    // end of file with no record yet from this byte: flush a partial header, tag header or tag
    if (stream_end && !emit) begin
      if (phase_next == PH_SIG) begin
        emit        = 1'b1;
        emit_status = ST_BAD_HDR;
        emit_kind   = RK_ZERO;
      end else if (phase_next == PH_THEAD && field_count_next != 4'd0) begin
        emit        = 1'b1;
        emit_status = ST_SHORT;
        emit_kind   = RK_RECORD;
      end else if (phase_next == PH_PAYLOAD || phase_next == PH_PREV) begin
        emit        = 1'b1;
        emit_status = ST_TAG;
        emit_kind   = RK_RECORD;
      end
    end
  end

  always_comb begin
    res             = '0;
    res.status      = emit_status;
    res_valid       = accept && emit;
    unique case (emit_kind)
      RK_HEADER: begin
        res.position    = rec_low_next;
        res.media_flags = rec_fields[15:8];
        res.packet_type = rec_fields[7:0];
      end
      RK_RECORD: begin
        res.extra_valid = extra_count_next;
        res.tag_type    = rec_fields_next[7:0];
        res.data_size   = rec_fields_next[31:8];
        res.timestamp   = rec_fields_next[63:32];
        res.stream_id   = rec_low_next[23:0];
        res.position    = start_ext[31:0];
        if (extra_count_next >= EX_FLAGS) begin
          res.media_flags = rec_low_next[31:24];
        end
        if (extra_count_next >= EX_PTYPE) begin
          res.packet_type = rec_ptype_next;
        end
        if (extra_count_next >= EX_CTIME) begin
          res.composition_time = rec_ctime_next;
        end
      end
      RK_ZERO: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && stream_end)) begin
      phase         <= PH_SIG;
      byte_position <= '0;
      field_count   <= '0;
      skip_target   <= '0;
      payload_left  <= '0;
      tags_seen     <= '0;
      rec_fields    <= '0;
      rec_low       <= '0;
      rec_ptype     <= '0;
      rec_ctime     <= '0;
      extra_count   <= EX_NONE;
      tag_start     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= pos_inc;
      field_count   <= field_count_next;
      skip_target   <= skip_target_next;
      payload_left  <= payload_left_next;
      tags_seen     <= tags_seen_next;
      rec_fields    <= rec_fields_next;
      rec_low       <= rec_low_next;
      rec_ptype     <= rec_ptype_next;
      rec_ctime     <= rec_ctime_next;
      extra_count   <= extra_count_next;
      tag_start     <= tag_start_next;
    end
  end

endmodule

`default_nettype wire

// File: design/flv_tag_stream_parser.sv
// a record is held in the output register (or in the skid register while the master side stalls)
// before it reaches the master side; one byte per cycle while the skid stage is empty;
// the byte parser updates its field state in a single step; an output register plus a skid stage keep the
// slave side open while one record waits; reset (rst, synchronous, active high) clears the parser to the
// signature phase, empties the output stages and sets tag_limit to 10000; tlast also returns to signature phase
`default_nettype none

module flv_tag_stream_parser
  import flvtp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_wen,
  input  wire  [15:0]  cfg_wdata,  // tag_limit
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,    // data_byte
  input  wire          s_tlast,    // stream_end
  output logic         m_tvalid,
  input  wire          m_tready,
  // tag_type, data_size, timestamp, stream_id, position, media_flags, packet_type,
  // composition_time
  output logic [159:0] m_tdata,
  output logic [3:0]   m_tuser     // status, extra_valid
);

  logic [15:0] tag_limit;
  logic        accept;
  logic        res_valid;
  rec_t        res;
  rec_t        out_rec;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_limit <= TAG_LIMIT_RESET;
    end else if (cfg_wen) begin
      tag_limit <= cfg_wdata;
    end
  end

  flvtp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .stream_end(s_tlast),
    .tag_limit (tag_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  flvtp_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (s_tready),
    .in_data  (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_rec)
  );

  assign m_tdata = {out_rec.composition_time, out_rec.packet_type, out_rec.media_flags,
                    out_rec.position, out_rec.stream_id, out_rec.timestamp,
                    out_rec.data_size, out_rec.tag_type};
  assign m_tuser = {out_rec.extra_valid, out_rec.status};

endmodule

`default_nettype wire

// File: bench/tb_flv_tag_stream_parser.sv
`default_nettype none

module tb_flv_tag_stream_parser
  import flvtp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 60;
  localparam int SHOWN_MISMATCHES = 10;

  class flv_record_predictor;
    logic [15:0] tag_limit;
    phase_t      phase;
    logic [31:0] byte_pos;
    logic [31:0] skip_target;
    logic [31:0] tag_start;
    logic [23:0] payload_left;
    logic [15:0] tags_seen;
    logic [63:0] hdr_word;
    logic [63:0] extra_word;
    int unsigned fcount;
    int unsigned extra_cnt;
    rec_t        pending_records[$];
    int unsigned bad_records;

    function new();
      tag_limit = TAG_LIMIT_RESET;
      bad_records = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_SIG;
      byte_pos = '0;
      skip_target = '0;
      tag_start = '0;
      payload_left = '0;
      tags_seen = '0;
      hdr_word = '0;
      extra_word = '0;
      fcount = 0;
      extra_cnt = 0;
    endfunction

    function void set_limit(logic [15:0] v);
      tag_limit = v;
    endfunction

    function rec_t tag_record(status_t st);
      rec_t r;
      r = '0;
      r.status = st;
      r.tag_type = hdr_word[7:0];
      r.data_size = hdr_word[31:8];
      r.timestamp = hdr_word[63:32];
      r.stream_id = extra_word[23:0];
      r.position = tag_start;
      if (extra_cnt >= 1) r.media_flags = extra_word[31:24];
      if (extra_cnt >= 2) r.packet_type = extra_word[39:32];
      if (extra_cnt >= 3) r.composition_time = extra_word[63:40];
      r.extra_valid = extra_cnt[1:0];
      return r;
    endfunction

    // returns 1 unless the parser was already stopped when the byte came
    function bit take_byte(logic [7:0] b, logic last);
      logic [31:0] pos;
      logic [31:0] nxt;
      logic [23:0] size;
      logic [7:0]  ty;
      logic [7:0]  mf;
      logic [7:0]  sig;
      int unsigned idx;
      bit          emitted;
      bit          used;
      bit          avc;
      rec_t        r;
      pos = byte_pos;
      nxt = pos + 32'd1;
      idx = fcount;
      emitted = 0;
      used = (phase != PH_STOP);
      sig = (idx == 0) ? SIG_F : (idx == 1) ? SIG_L : SIG_V;
      case (phase)
        PH_SIG: begin
          if (idx < 3 && b != sig) begin
            r = '0;
            r.status = ST_BAD_HDR;
            pending_records.push_back(r);
            emitted = 1;
            phase = PH_STOP;
          end else begin
            if (idx == 3) hdr_word[7:0] = b;
            else if (idx == 4) hdr_word[15:8] = b;
            else if (idx > 4) extra_word = {32'd0, extra_word[23:0], b};
            fcount = idx + 1;
            if (idx >= FILE_HDR_LAST) begin
              r = '0;
              r.status = ST_HEADER;
              r.position = extra_word[31:0];
              r.media_flags = hdr_word[15:8];
              r.packet_type = hdr_word[7:0];
              pending_records.push_back(r);
              emitted = 1;
              skip_target = extra_word[31:0] + 32'(PREV_SIZE_PAD);
              phase = (skip_target > nxt) ? PH_SKIP : PH_THEAD;
              fcount = 0;
              hdr_word = '0;
              extra_word = '0;
            end
          end
        end
        PH_SKIP: begin
          if (nxt >= skip_target) phase = PH_THEAD;
        end
        PH_THEAD: begin
          if (idx == 0 && tags_seen >= tag_limit) begin
            phase = PH_STOP;
          end else begin
            if (idx == 0) begin
              tag_start = pos;
              hdr_word = '0;
              extra_word = '0;
              extra_cnt = 0;
            end
            case (idx)
              0: hdr_word[7:0] = b;
              1: hdr_word[31:24] = b;
              2: hdr_word[23:16] = b;
              3: hdr_word[15:8] = b;
              4: hdr_word[55:48] = b;
              5: hdr_word[47:40] = b;
              6: hdr_word[39:32] = b;
              7: hdr_word[63:56] = b;
              8: extra_word[23:16] = b;
              9: extra_word[15:8] = b;
              10: extra_word[7:0] = b;
              default: ;
            endcase
            fcount = idx + 1;
            if (idx >= TAG_HDR_LAST) begin
              size = hdr_word[31:8];
              ty = hdr_word[7:0];
              if (((ty == TAG_AUDIO || ty == TAG_VIDEO) && size == 0) ||
                  (ty == TAG_SCRIPT && size < 2)) begin
                pending_records.push_back(tag_record(ST_SHORT));
                emitted = 1;
                phase = PH_STOP;
              end else begin
                payload_left = size;
                fcount = 0;
                phase = (size != 0) ? PH_PAYLOAD : PH_PREV;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          ty = hdr_word[7:0];
          size = hdr_word[31:8];
          mf = extra_word[31:24];
          avc = ty == TAG_VIDEO && (mf[3:0] == CODEC_AVC || mf[3:0] == CODEC_HEVC) &&
                size >= 5;
          if ((ty == TAG_AUDIO || ty == TAG_VIDEO) && idx == 0) begin
            extra_word[31:24] = b;
            extra_cnt = 1;
          end else if (avc) begin
            if (idx == 1) begin
              extra_word[39:32] = b;
              extra_cnt = 2;
            end else if (idx == 2) begin
              extra_word[63:56] = b;
            end else if (idx == 3) begin
              extra_word[55:48] = b;
            end else if (idx == 4) begin
              extra_word[47:40] = b;
              extra_cnt = 3;
            end
          end else if (ty == TAG_AUDIO && idx == 1 && mf[7:4] == SOUND_AAC) begin
            extra_word[39:32] = b;
            extra_cnt = 2;
          end
          if (fcount < FC_MAX) fcount++;
          payload_left = payload_left - 24'd1;
          if (payload_left == 0) begin
            fcount = 0;
            phase = PH_PREV;
          end
        end
        PH_PREV: begin
          fcount = idx + 1;
          if (fcount >= PREV_SIZE_LEN) begin
            pending_records.push_back(tag_record(ST_TAG));
            emitted = 1;
            if (tags_seen != 16'hFFFF) tags_seen++;
            fcount = 0;
            phase = PH_THEAD;
          end
        end
        default: ;
      endcase
      if (last && !emitted) begin
        if (phase == PH_SIG) begin
          r = '0;
          r.status = ST_BAD_HDR;
          pending_records.push_back(r);
        end else if (phase == PH_THEAD && fcount > 0) begin
          pending_records.push_back(tag_record(ST_SHORT));
        end else if (phase == PH_PAYLOAD || phase == PH_PREV) begin
          pending_records.push_back(tag_record(ST_TAG));
        end
      end
      byte_pos = nxt;
      if (last) restart();
      return used;
    endfunction

    function void flag(string what, rec_t want, rec_t got);
      bad_records++;
      if (bad_records <= SHOWN_MISMATCHES)
        $display("%s: expected %h, got %h", what, want, got);
    endfunction

    function void check_record(rec_t got);
      rec_t  want;
      string diffs;
      if (pending_records.size() == 0) begin
        flag("record with nothing pending", '0, got);
        return;
      end
      want = pending_records.pop_front();
      diffs = "";
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.extra_valid !== want.extra_valid) diffs = {diffs, " extra_valid"};
      if (got.tag_type !== want.tag_type) diffs = {diffs, " tag_type"};
      if (got.data_size !== want.data_size) diffs = {diffs, " data_size"};
      if (got.timestamp !== want.timestamp) diffs = {diffs, " timestamp"};
      if (got.stream_id !== want.stream_id) diffs = {diffs, " stream_id"};
      if (got.position !== want.position) diffs = {diffs, " position"};
      if (got.media_flags !== want.media_flags) diffs = {diffs, " media_flags"};
      if (got.packet_type !== want.packet_type) diffs = {diffs, " packet_type"};
      if (got.composition_time !== want.composition_time)
        diffs = {diffs, " composition_time"};
      if (diffs != "") flag({"record mismatch in", diffs}, want, got);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  wire          s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  wire          m_tvalid;
  logic         m_tready = 1'b0;
  wire  [159:0] m_tdata;
  wire  [3:0]   m_tuser;

  flv_record_predictor tracker = new();
  logic [7:0]          flv_bytes[$];
  int                  sent_bytes = 0;
  int                  src_idle_pct = 0;
  int                  sink_stall_pct = 0;
  int                  cycles = 0;

  flv_tag_stream_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic rec_t unpack_record(logic [159:0] d, logic [3:0] u);
    rec_t r;
    r.status = status_t'(u[1:0]);
    r.extra_valid = u[3:2];
    r.tag_type = d[7:0];
    r.data_size = d[31:8];
    r.timestamp = d[63:32];
    r.stream_id = d[87:64];
    r.position = d[119:88];
    r.media_flags = d[127:120];
    r.packet_type = d[135:128];
    r.composition_time = d[159:136];
    return r;
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && m_tvalid && m_tready) tracker.check_record(unpack_record(m_tdata, m_tuser));
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(tracker.take_byte(b, last));
    sent_bytes++;
  endtask

  task automatic send_file();
    for (int i = 0; i < flv_bytes.size(); i++) send_byte(flv_bytes[i], i == flv_bytes.size() - 1);
  endtask

  task automatic write_tag_limit(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tracker.set_limit(v);
  endtask

  task automatic push_random(input int n);
    repeat (n) flv_bytes.push_back(8'($urandom));
  endtask

  task automatic build_file();
    logic [31:0] offset;
    logic [31:0] target;
    logic [23:0] size;
    logic [7:0]  ty;
    logic [7:0]  first;
    logic [3:0]  codec;
    int          r;
    int          k;
    int          cut;
    bit          huge;
    flv_bytes = '{SIG_F, SIG_L, SIG_V};
    if ($urandom_range(99) < 5) begin
      k = $urandom_range(2);
      flv_bytes[k] = flv_bytes[k] ^ 8'($urandom_range(1, 255));
    end
    push_random(2);
    huge = 0;
    r = $urandom_range(99);
    if (r < 60) offset = 32'd9;
    else if (r < 75) offset = 32'($urandom_range(8));
    else if (r < 88) offset = 32'(10 + $urandom_range(12));
    else if (r < 94) offset = 32'hFFFF_FFFC + 32'($urandom_range(3));
    else begin
      offset = $urandom;
      huge = 1;
    end
    flv_bytes.push_back(offset[31:24]);
    flv_bytes.push_back(offset[23:16]);
    flv_bytes.push_back(offset[15:8]);
    flv_bytes.push_back(offset[7:0]);
    if (huge) begin
      push_random($urandom_range(1, 5));
      return;
    end
    target = offset + 32'd4;
    if (target > 32'd9) push_random(int'(target) - 9);
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(99);
      if (r < 40) ty = TAG_VIDEO;
      else if (r < 75) ty = TAG_AUDIO;
      else if (r < 88) ty = TAG_SCRIPT;
      else ty = 8'($urandom);
      r = $urandom_range(99);
      if (r < 3) begin
        size = 24'($urandom);
        huge = 1;
      end else if (r < 9) begin
        size = (ty == TAG_SCRIPT) ? 24'($urandom_range(1)) : 24'd0;
      end else begin
        size = 24'($urandom_range(1, 12));
      end
      flv_bytes.push_back(ty);
      flv_bytes.push_back(size[23:16]);
      flv_bytes.push_back(size[15:8]);
      flv_bytes.push_back(size[7:0]);
      push_random(4);
      if ($urandom_range(3) == 0) push_random(3);
      else repeat (3) flv_bytes.push_back(8'd0);
      if (size != 0) begin
        r = $urandom_range(5);
        codec = (r < 2) ? CODEC_AVC : (r < 4) ? CODEC_HEVC : 4'($urandom);
        if (ty == TAG_VIDEO) first = {4'($urandom), codec};
        else if (ty == TAG_AUDIO)
          first = {($urandom_range(2) == 0) ? 4'($urandom) : SOUND_AAC, 4'($urandom)};
        else first = 8'($urandom);
        flv_bytes.push_back(first);
      end
      if (huge) begin
        push_random($urandom_range(0, 4));
        return;
      end
      if (size != 0) push_random(int'(size) - 1);
      push_random(4);
    end
    if ($urandom_range(99) < 25) begin
      cut = $urandom_range(1, flv_bytes.size());
      while (flv_bytes.size() > cut) void'(flv_bytes.pop_back());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    flv_bytes = '{SIG_F, 8'h51, SIG_V};
    send_file();
    flv_bytes = '{SIG_F, SIG_L};
    send_file();
    // data offset of zero, then a video tag with no payload
    flv_bytes = '{SIG_F, SIG_L, SIG_V, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00,
                  TAG_VIDEO, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF};
    send_file();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: write_tag_limit(16'd1);
        2: write_tag_limit(16'hFFFF);
        3: write_tag_limit(16'd2);
        4: write_tag_limit(16'($urandom_range(1, 4)));
        default: ;
      endcase
      case (p)
        1: begin
          src_idle_pct = 51;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 51;
        end
        3: begin
          src_idle_pct = 31;
          sink_stall_pct = 31;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      sent_bytes = 0;
      while (sent_bytes < PHASE_BYTES) begin
        build_file();
        send_file();
      end
    end

    s_tvalid <= 1'b0;
    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.bad_records == 0 && tracker.pending_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
